@@ rtl/lhfs_pkg.sv @@
// Package for the link health failover selector: defaults, port layout, register codes, types.
package lhfs_pkg;

  // Parameter defaults
  localparam int NUM_PATHS_DEF   = 4;
  localparam int WINDOW_LEN_DEF  = 8;
  localparam int MISS_LIMIT_DEF  = 60;
  localparam int RETRY_TICKS_DEF = 15;

  // Fixed field widths of the stream payloads
  localparam int MASK_W     = 4;
  localparam int PATH_W     = 2;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // Item kinds carried on s_tuser
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_STATS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCRIPT_ENABLED = 2'd2;

  // Per-lane status toward the merge stage (state after the current item)
  typedef struct packed {
    logic up;
    logic up_ev;
    logic down_ev;
    logic kill;
  } lane_status_t;

  // Selection and call outcome for the current item
  typedef struct packed {
    logic              selected_valid;
    logic [PATH_W-1:0] selected_path;
    logic              call_request;
    logic              call_is_retry;
  } sel_result_t;

endpackage

@@ rtl/lhfs_lane.sv @@
// One path lane: reply window, fill count, up state and miss run counter.
module lhfs_lane #(
  parameter int WINDOW_LEN = lhfs_pkg::WINDOW_LEN_DEF,
  parameter int MISS_LIMIT = lhfs_pkg::MISS_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  logic                  restart,
  input  logic                  keep_stats,
  input  logic                  reply,
  output lhfs_pkg::lane_status_t status
);
  import lhfs_pkg::*;

  localparam int FC_W = $clog2(WINDOW_LEN + 1);
  localparam int MR_W = (MISS_LIMIT > 1) ? $clog2(MISS_LIMIT) : 1;

  logic [WINDOW_LEN-1:0] window, window_next, win_shift;
  logic [FC_W-1:0]       fill, fill_next;
  logic                  up, up_next;
  logic [MR_W-1:0]       miss, miss_next;
  logic [FC_W:0]         fill_inc;
  logic [MR_W:0]         miss_inc;
  logic                  full_now, kill_hit, go_up, go_down;

  // Tick update terms
  always_comb begin
    win_shift = WINDOW_LEN'({window, reply});
    fill_inc  = {1'b0, fill} + (FC_W+1)'(1);
    full_now  = fill_inc >= (FC_W+1)'(WINDOW_LEN);
    miss_inc  = {1'b0, miss} + (MR_W+1)'(1);
    kill_hit  = !reply && (miss_inc >= (MR_W+1)'(MISS_LIMIT));
    go_up     = full_now && (&win_shift) && !up;
    go_down   = full_now && !(|win_shift) && up;
  end

  // Next state per item kind
  always_comb begin
    window_next = window;
    fill_next   = fill;
    up_next     = up;
    miss_next   = miss;
    if (tick) begin
      window_next = win_shift;
      if (fill < FC_W'(WINDOW_LEN)) begin
        fill_next = fill_inc[FC_W-1:0];
      end
      if (reply || kill_hit) begin
        miss_next = '0;
      end else begin
        miss_next = miss_inc[MR_W-1:0];
      end
      if (go_up) begin
        up_next = 1'b1;
      end else if (go_down) begin
        up_next = 1'b0;
      end
    end else if (restart) begin
      miss_next = '0;
      if (!keep_stats) begin
        window_next = '0;
        fill_next   = FC_W'(WINDOW_LEN);
        up_next     = 1'b0;
      end
    end
  end

  always_comb begin
    status.up      = up_next;
    status.up_ev   = tick && go_up;
    status.down_ev = tick && go_down;
    status.kill    = tick && kill_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      fill   <= '0;
      up     <= 1'b0;
      miss   <= '0;
    end else begin
      window <= window_next;
      fill   <= fill_next;
      up     <= up_next;
      miss   <= miss_next;
    end
  end

endmodule

@@ rtl/lhfs_select.sv @@
// Merge stage: lowest up path search, selection hold and switch call retry control.
module lhfs_select #(
  parameter int NUM_PATHS   = lhfs_pkg::NUM_PATHS_DEF,
  parameter int RETRY_TICKS = lhfs_pkg::RETRY_TICKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic [NUM_PATHS-1:0]   restart_lane,
  input  logic [NUM_PATHS-1:0]   up_next,
  input  logic                   priority_mode,
  input  logic                   script_enabled,
  input  logic                   call_failed,
  output lhfs_pkg::sel_result_t  result
);
  import lhfs_pkg::*;

  localparam int CH_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
  localparam int RW_W = $clog2(RETRY_TICKS + 1);

  logic [CH_W-1:0] chosen, chosen_next, first;
  logic            chosen_valid, chosen_valid_next;
  logic [RW_W-1:0] retry_wait, retry_wait_next;
  logic [RW_W:0]   retry_inc;
  logic            call_pending, call_pending_next;
  logic            call_outstanding, call_outstanding_next;
  logic            first_valid, change, pend_now, req, retry;

  // Lowest-numbered up path
  always_comb begin
    first       = '0;
    first_valid = |up_next;
    for (int p = NUM_PATHS - 1; p >= 0; p--) begin
      if (up_next[p]) begin
        first = CH_W'(p);
      end
    end
  end

  // Selection and call control
  always_comb begin
    chosen_next           = chosen;
    chosen_valid_next     = chosen_valid;
    retry_wait_next       = retry_wait;
    call_pending_next     = call_pending;
    call_outstanding_next = call_outstanding;
    req                   = 1'b0;
    retry                 = 1'b0;
    retry_inc             = {1'b0, retry_wait} + (RW_W+1)'(1);
    pend_now              = call_outstanding ? call_failed : call_pending;
    if (priority_mode) begin
      change = first_valid && (!chosen_valid || chosen != first);
    end else begin
      change = first_valid && (!chosen_valid || !up_next[chosen]);
    end
    if (tick) begin
      call_pending_next     = pend_now;
      call_outstanding_next = 1'b0;
      if (change) begin
        retry_wait_next   = '0;
        chosen_next       = first;
        chosen_valid_next = 1'b1;
        if (script_enabled) begin
          req                   = 1'b1;
          call_pending_next     = 1'b0;
          call_outstanding_next = 1'b1;
        end
      end else if (pend_now) begin
        if (!script_enabled) begin
          retry_wait_next = '0;
        end else if (retry_inc > (RW_W+1)'(RETRY_TICKS)) begin
          retry_wait_next       = '0;
          req                   = 1'b1;
          retry                 = 1'b1;
          call_pending_next     = 1'b0;
          call_outstanding_next = 1'b1;
        end else begin
          retry_wait_next = retry_inc[RW_W-1:0];
        end
      end
    end else if (chosen_valid && restart_lane[chosen]) begin
      // restart of the selected path drops the selection
      chosen_valid_next = 1'b0;
    end
  end

  always_comb begin
    result.selected_valid = chosen_valid_next;
    result.selected_path  = chosen_valid_next ? PATH_W'(chosen_next) : '0;
    result.call_request   = req;
    result.call_is_retry  = retry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chosen           <= '0;
      chosen_valid     <= 1'b0;
      retry_wait       <= '0;
      call_pending     <= 1'b0;
      call_outstanding <= 1'b0;
    end else begin
      chosen           <= chosen_next;
      chosen_valid     <= chosen_valid_next;
      retry_wait       <= retry_wait_next;
      call_pending     <= call_pending_next;
      call_outstanding <= call_outstanding_next;
    end
  end

endmodule

@@ rtl/link_health_failover_selector.sv @@
// Top level of the link health failover selector.
// Takes one item per clock: a one-second tick (s_tuser = 0) carrying a reply bit per path,
// or a restart event (s_tuser = 1) carrying a restart bit per path. Every item gives exactly
// one result, registered and shown on the master side in the cycle after acceptance. Each path
// has its own lane that updates its window, fill count, up state and miss run in the cycle
// of acceptance; the merge stage picks the lowest up path and runs switch call retry control
// in the same cycle, so the sustained rate is one item per cycle, limited only by the output
// register (s_tready follows m_tready while a result is held). Configuration writes take
// effect at the next clock and must be made while no item is in flight.
module link_health_failover_selector #(
  parameter int NUM_PATHS   = lhfs_pkg::NUM_PATHS_DEF,
  parameter int WINDOW_LEN  = lhfs_pkg::WINDOW_LEN_DEF,
  parameter int MISS_LIMIT  = lhfs_pkg::MISS_LIMIT_DEF,
  parameter int RETRY_TICKS = lhfs_pkg::RETRY_TICKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // reply_mask[3:0], restart_mask[7:4], call_failed[8], zero fill
  input  logic [lhfs_pkg::S_TDATA_W-1:0]   s_tdata,
  // func[0]
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // selected_valid[0], selected_path[2:1], call_request[3], call_is_retry[4],
  // up_event_mask[8:5], down_event_mask[12:9], kill_mask[16:13], link_up_mask[20:17]
  output logic [lhfs_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [lhfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lhfs_pkg::*;

  localparam int EXT_W = (NUM_PATHS > MASK_W) ? NUM_PATHS : MASK_W;

  logic                 priority_mode, keep_stats, script_enabled;
  logic                 accept, tick, restart;
  logic [EXT_W-1:0]     reply_ext, restart_ext;
  logic [NUM_PATHS-1:0] restart_lane, up_vec, up_ev_vec, down_ev_vec, kill_vec;
  logic [EXT_W-1:0]     up_ext, up_ev_ext, down_ev_ext, kill_ext;
  lane_status_t         status [NUM_PATHS];
  sel_result_t          sel;
  logic [M_TDATA_W-1:0] result_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      priority_mode  <= 1'b0;
      keep_stats     <= 1'b0;
      script_enabled <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRIORITY_MODE:  priority_mode  <= cfg_data[0];
        REG_KEEP_STATS:     keep_stats     <= cfg_data[0];
        REG_SCRIPT_ENABLED: script_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input handshake and item decode
  assign s_tready     = !m_tvalid || m_tready;
  assign accept       = s_tvalid && s_tready;
  assign tick         = accept && (s_tuser == FUNC_TICK);
  assign restart      = accept && (s_tuser == FUNC_RESTART);
  assign reply_ext    = EXT_W'(s_tdata[MASK_W-1:0]);
  assign restart_ext  = EXT_W'(s_tdata[2*MASK_W-1:MASK_W]);
  assign restart_lane = restart ? restart_ext[NUM_PATHS-1:0] : '0;

  // Path lanes
  for (genvar p = 0; p < NUM_PATHS; p++) begin : g_lane
    lhfs_lane #(
      .WINDOW_LEN (WINDOW_LEN),
      .MISS_LIMIT (MISS_LIMIT)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .tick       (tick),
      .restart    (restart_lane[p]),
      .keep_stats (keep_stats),
      .reply      (reply_ext[p]),
      .status     (status[p])
    );
    assign up_vec[p]      = status[p].up;
    assign up_ev_vec[p]   = status[p].up_ev;
    assign down_ev_vec[p] = status[p].down_ev;
    assign kill_vec[p]    = status[p].kill;
  end

  // Merge stage
  lhfs_select #(
    .NUM_PATHS   (NUM_PATHS),
    .RETRY_TICKS (RETRY_TICKS)
  ) u_select (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .restart_lane   (restart_lane),
    .up_next        (up_vec),
    .priority_mode  (priority_mode),
    .script_enabled (script_enabled),
    .call_failed    (s_tdata[2*MASK_W]),
    .result         (sel)
  );

  // Result packing; paths above the mask width are dropped
  assign up_ext      = EXT_W'(up_vec);
  assign up_ev_ext   = EXT_W'(up_ev_vec);
  assign down_ev_ext = EXT_W'(down_ev_vec);
  assign kill_ext    = EXT_W'(kill_vec);
  assign result_data = M_TDATA_W'({up_ext[MASK_W-1:0], kill_ext[MASK_W-1:0],
                                   down_ev_ext[MASK_W-1:0], up_ev_ext[MASK_W-1:0],
                                   sel.call_is_retry, sel.call_request,
                                   sel.selected_path, sel.selected_valid});

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_data;
    end
  end

endmodule

@@ rtl/lhfs_checker.sv @@
// Port-level checks for the link health failover selector, bound to the top level.
module lhfs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic [lhfs_pkg::M_TDATA_W-1:0]   m_tdata
);
  import lhfs_pkg::*;

  // Every accepted item shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // A retry is always a call request
  a_retry_is_call: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("retry flagged without call request");

  // Up events agree with the up mask, down events with its complement
  a_events_vs_up: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[8:5] & ~m_tdata[20:17]) == 4'd0) &&
                 ((m_tdata[12:9] & m_tdata[20:17]) == 4'd0))
    else $error("event mask disagrees with up mask");

  // A restart event gives no call, no events and no kills
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_RESTART) |=>
      !m_tdata[3] && !m_tdata[4] && (m_tdata[16:5] == 12'd0))
    else $error("restart event produced call or events");

endmodule

bind link_health_failover_selector lhfs_checker u_lhfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata)
);

@@ dv/link_health_failover_selector_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the link health failover selector: directed and random items, scoreboard check.
module link_health_failover_selector_tb;
  import lhfs_pkg::*;

  localparam int NP       = NUM_PATHS_DEF;
  localparam int WIN      = WINDOW_LEN_DEF;
  localparam int MISS_LIM = MISS_LIMIT_DEF;
  localparam int RETRY    = RETRY_TICKS_DEF;

  // Result item, same layout as m_tdata (lowest field in the lowest bits)
  typedef struct packed {
    bit [M_TDATA_W-22:0] pad;
    bit [MASK_W-1:0]     link_up;
    bit [MASK_W-1:0]     kill;
    bit [MASK_W-1:0]     down_ev;
    bit [MASK_W-1:0]     up_ev;
    bit                  call_retry;
    bit                  call_req;
    bit [PATH_W-1:0]     sel_path;
    bit                  sel_valid;
  } outcome_t;

  // Reply pattern a path follows for a while in the random part
  typedef enum int {LANE_REPLY, LANE_SILENT, LANE_FLAKY, LANE_MOSTLY} lane_mode_e;

  // Path health and selection predictor plus the queue of selections still due
  class failover_scoreboard;
    bit [WIN-1:0]      reply_hist[NP];
    bit [3:0]          fill[NP];
    bit [5:0]          miss_run[NP];
    bit [NP-1:0]       up_state;
    bit [PATH_W-1:0]   sel_path;
    bit                sel_valid;
    bit [4:0]          retry_wait;
    bit                call_pending;
    bit                call_outstanding;
    bit                prio_mode;
    bit                keep_stats;
    bit                script_en;
    logic [M_TDATA_W-1:0] selections_due[$];
    int                mismatch_count;

    function new();
      for (int p = 0; p < NP; p++) begin
        reply_hist[p] = '0;
        fill[p] = '0;
        miss_run[p] = '0;
      end
      up_state = '0;
      sel_path = '0;
      sel_valid = 0;
      retry_wait = '0;
      call_pending = 0;
      call_outstanding = 0;
      prio_mode = 0;
      keep_stats = 0;
      script_en = 1;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        REG_PRIORITY_MODE:  prio_mode = val;
        REG_KEEP_STATS:     keep_stats = val;
        REG_SCRIPT_ENABLED: script_en = val;
        default: ;
      endcase
    endfunction

    function int due_count();
      return selections_due.size();
    endfunction

    // Accepted input item: advance the path state and queue the selection it yields
    function void take_item(logic kind, logic [MASK_W-1:0] replies,
                            logic [MASK_W-1:0] restarts, logic failed);
      outcome_t e;
      bit first_ok;
      bit [PATH_W-1:0] first;
      bit do_switch;
      e = '0;
      if (kind == FUNC_RESTART) begin
        for (int p = 0; p < NP; p++) begin
          if (restarts[p]) begin
            if (!keep_stats) begin
              up_state[p] = 0;
              reply_hist[p] = '0;
              fill[p] = 4'(WIN);
            end
            miss_run[p] = '0;
            if (sel_valid && sel_path == p) sel_valid = 0;
          end
        end
      end else begin
        // outcome of the call requested on the previous tick
        if (call_outstanding) begin
          call_pending = failed;
          call_outstanding = 0;
        end
        first_ok = 0;
        first = '0;
        for (int p = 0; p < NP; p++) begin
          reply_hist[p] = {reply_hist[p][WIN-2:0], replies[p]};
          if (fill[p] < WIN) fill[p]++;
          if (replies[p]) begin
            miss_run[p] = '0;
          end else begin
            miss_run[p]++;
            if (miss_run[p] >= MISS_LIM) begin
              e.kill[p] = 1;
              miss_run[p] = '0;
            end
          end
          // up/down only once the window is full
          if (fill[p] >= WIN) begin
            if (reply_hist[p] == '1 && !up_state[p]) begin
              up_state[p] = 1;
              e.up_ev[p] = 1;
            end
            if (reply_hist[p] == '0 && up_state[p]) begin
              up_state[p] = 0;
              e.down_ev[p] = 1;
            end
          end
          if (up_state[p] && !first_ok) begin
            first_ok = 1;
            first = PATH_W'(p);
          end
        end
        do_switch = first_ok &&
                    (!sel_valid || (prio_mode ? sel_path != first : !up_state[sel_path]));
        if (do_switch) begin
          retry_wait = '0;
          sel_path = first;
          sel_valid = 1;
          if (script_en) begin
            e.call_req = 1;
            call_pending = 0;
            call_outstanding = 1;
          end
        end else if (call_pending) begin
          if (!script_en) begin
            retry_wait = '0;
          end else begin
            retry_wait++;
            if (retry_wait > RETRY) begin
              retry_wait = '0;
              e.call_req = 1;
              e.call_retry = 1;
              call_pending = 0;
              call_outstanding = 1;
            end
          end
        end
      end
      e.sel_valid = sel_valid;
      e.sel_path = sel_valid ? sel_path : '0;
      e.link_up = up_state;
      selections_due.insert(selections_due.size(), e);
    endfunction

    function logic [3:0] field_of(logic [M_TDATA_W-1:0] v, int i);
      case (i)
        0: return {3'b0, v[0]};
        1: return {2'b0, v[2:1]};
        2: return {3'b0, v[3]};
        3: return {3'b0, v[4]};
        4: return v[8:5];
        5: return v[12:9];
        6: return v[16:13];
        default: return v[20:17];
      endcase
    endfunction

    function string field_label(int i);
      case (i)
        0: return "selected_valid";
        1: return "selected_path";
        2: return "call_request";
        3: return "call_is_retry";
        4: return "up_event_mask";
        5: return "down_event_mask";
        6: return "kill_mask";
        default: return "link_up_mask";
      endcase
    endfunction

    // Accepted result item: compare against the oldest selection due
    function void check_selection(logic [M_TDATA_W-1:0] got);
      logic [M_TDATA_W-1:0] want;
      bit bad;
      if (selections_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: result %h with nothing due", got);
        return;
      end
      want = selections_due.pop_front();
      bad = 0;
      for (int i = 0; i < 8; i++) begin
        if (field_of(got, i) !== field_of(want, i)) begin
          bad = 1;
          if (mismatch_count < 10)
            $display("ERROR: %s expected %h got %h", field_label(i),
                     field_of(want, i), field_of(got, i));
        end
      end
      if (bad) mismatch_count++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // reply_mask[3:0], restart_mask[7:4], call_failed[8], zero fill
  logic [S_TDATA_W-1:0]  s_tdata;
  // func[0]
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // selected_valid[0], selected_path[2:1], call_request[3], call_is_retry[4],
  // up_event_mask[8:5], down_event_mask[12:9], kill_mask[16:13], link_up_mask[20:17]
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  failover_scoreboard board;
  bit                 idle_on;
  int                 stall_left;
  lane_mode_e         lane_mode[NP];
  int                 lane_left[NP];

  link_health_failover_selector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: ready, with random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_selection(m_tdata);
      if (s_tvalid && s_tready)
        board.take_item(s_tuser, s_tdata[3:0], s_tdata[7:4], s_tdata[8]);
    end
  end

  // Present one item, maybe after a gap, and hold it until accepted
  task automatic send_item(input logic kind, input logic [MASK_W-1:0] replies,
                           input logic [MASK_W-1:0] restarts, input logic failed);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_TDATA_W - 9){1'b0}}, failed, restarts, replies};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Random item: each path follows a reply pattern for a stretch of items
  task automatic send_random_item();
    logic [MASK_W-1:0] replies;
    logic [MASK_W-1:0] restarts;
    logic kind;
    for (int p = 0; p < NP; p++) begin
      if (lane_left[p] == 0) begin
        lane_mode[p] = lane_mode_e'($urandom_range(0, 3));
        lane_left[p] = $urandom_range(10, 120);
      end
      lane_left[p]--;
      case (lane_mode[p])
        LANE_REPLY:  replies[p] = 1'b1;
        LANE_SILENT: replies[p] = 1'b0;
        LANE_FLAKY:  replies[p] = 1'($urandom_range(0, 1));
        default:     replies[p] = ($urandom_range(0, 7) != 0);
      endcase
    end
    kind = ($urandom_range(0, 19) == 0) ? FUNC_RESTART : FUNC_TICK;
    // restarts mostly hit one path so long miss runs can survive
    if (kind == FUNC_RESTART && $urandom_range(0, 3) != 0)
      restarts = MASK_W'(1) << $urandom_range(0, NP - 1);
    else
      restarts = MASK_W'($urandom());
    send_item(kind, replies, restarts, 1'($urandom_range(0, 1)));
  endtask

  // Wait until every due selection has come out, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.due_count() > 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers: {priority_mode, keep_stats, script_enabled}
  task automatic apply_settings(input bit [2:0] cfg);
    cfg_we <= 1'b1;
    cfg_index <= REG_PRIORITY_MODE;
    cfg_data <= cfg[2];
    board.set_reg(REG_PRIORITY_MODE, cfg[2]);
    @(posedge clk);
    cfg_index <= REG_KEEP_STATS;
    cfg_data <= cfg[1];
    board.set_reg(REG_KEEP_STATS, cfg[1]);
    @(posedge clk);
    cfg_index <= REG_SCRIPT_ENABLED;
    cfg_data <= cfg[0];
    board.set_reg(REG_SCRIPT_ENABLED, cfg[0]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit [2:0] plan[5];
    plan[0] = 3'b111;
    plan[1] = 3'b010;
    plan[2] = 3'b100;
    plan[3] = 3'b000;
    plan[4] = 3'b101;
    board = new();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= FUNC_TICK;
    s_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PRIORITY_MODE;
    cfg_data <= '0;
    idle_on <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset settings
    send_item(FUNC_TICK, 4'h0, 4'hF, 1'b1);     // short history, failure flag ignored
    send_item(FUNC_RESTART, 4'hF, 4'hF, 1'b1);  // restart marks windows full of misses
    repeat (8) send_item(FUNC_TICK, 4'hF, 4'h0, 1'b0);  // all paths up, switch call
    send_item(FUNC_TICK, 4'hE, 4'h0, 1'b1);     // call reported failed
    send_item(FUNC_RESTART, 4'h0, 4'h1, 1'b0);  // selected path restarts
    send_item(FUNC_TICK, 4'hE, 4'h0, 1'b0);     // move to the next up path
    send_item(FUNC_RESTART, 4'hA, 4'h0, 1'b1);  // restart with empty mask
    send_item(FUNC_TICK, 4'h0, 4'hF, 1'b1);     // all miss, call failed
    send_item(FUNC_TICK, 4'h5, 4'h0, 1'b0);

    // Random phases, one register setting each; last phase runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      apply_settings(plan[ph]);
      for (int n = 0; n < 80; n++) begin
        if (n % 40 == 0) idle_on = (ph < 4) && ($urandom_range(0, 2) != 0);
        send_random_item();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (board.mismatch_count == 0 && board.due_count() == 0) begin
      $display("link_health_failover_selector_tb: done, clean");
    end else begin
      $display("link_health_failover_selector_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("link_health_failover_selector_tb: done, errors");
    $finish;
  end

endmodule
